FILE: hdl/sparse_image_block_translator_core_assert.svh
// assertion macros for the checker file
`ifndef SPARSE_IMAGE_BLOCK_TRANSLATOR_CORE_ASSERT_SVH
`define SPARSE_IMAGE_BLOCK_TRANSLATOR_CORE_ASSERT_SVH

// same-cycle implication under the active-low reset
`define SIBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sibt assertion failed");

// next-cycle implication under the active-low reset
`define SIBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sibt assertion failed");

`endif

FILE: hdl/sibt_pkg.sv
// package: sizes, codes and shared types of the sparse image block translator
`timescale 1ns / 1ps

package sibt_pkg;

    localparam int MAX_L1_BITS = 6;
    localparam int MAX_L2_BITS = 6;
    localparam int L1_AW       = MAX_L1_BITS;
    localparam int L2_AW       = MAX_L2_BITS;
    localparam int STORE_AW    = MAX_L1_BITS + MAX_L2_BITS;
    localparam int L1_DEPTH    = 1 << MAX_L1_BITS;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    localparam int WORD_W = 64;
    localparam int OFS_W  = 48;
    localparam int PAT_W  = 32;
    localparam int SH_W   = 6;
    localparam int PADDR_W = 5;

    localparam int MIN_BLOCK_BITS = 9;
    localparam int MAX_BLOCK_BITS = 24;

    // low flag bits of a table word and the uniform mark among them
    localparam logic [WORD_W-1:0] LOW_FLAGS    = 64'h1ff;
    localparam logic [WORD_W-1:0] UNIFORM_MARK = 64'h2;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_UNIFORM = 3'd2;
    localparam logic [2:0] OP_LOAD_L1 = 3'd3;
    localparam logic [2:0] OP_LOAD_L2 = 3'd4;

    localparam logic [2:0] STATUS_MAPPED  = 3'd0;
    localparam logic [2:0] STATUS_UNALLOC = 3'd1;
    localparam logic [2:0] STATUS_UNIFORM = 3'd2;
    localparam logic [2:0] STATUS_ERROR   = 3'd3;
    localparam logic [2:0] STATUS_DONE    = 3'd4;

    localparam logic [1:0] FILL_NONE    = 2'd0;
    localparam logic [1:0] FILL_COPY    = 2'd1;
    localparam logic [1:0] FILL_PATTERN = 2'd2;

    localparam logic [1:0] REG_BLOCK_BITS = 2'd0;
    localparam logic [1:0] REG_L2_BITS    = 2'd1;
    localparam logic [1:0] REG_L1_BITS    = 2'd2;
    localparam logic [1:0] REG_FILE_END   = 2'd3;

    typedef struct packed {
        logic [4:0]       block_bits;
        logic [2:0]       l2_bits;
        logic [2:0]       l1_bits;
        logic [OFS_W-1:0] initial_file_end;
        logic             load_file_end;
    } sibt_cfg_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [OFS_W-1:0] mapped_offset;
        logic [PAT_W-1:0] pattern;
        logic [1:0]       fill_action;
        logic [OFS_W-1:0] new_table_offset;
        logic             l1_changed;
        logic             l2_changed;
        logic [OFS_W-1:0] file_end;
    } sibt_result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_L1_CHECK,
        S_CLEAR,
        S_L2_READ,
        S_L2_CHECK,
        S_UNI_WRITE,
        S_RESULT
    } sibt_state_t;

endpackage

FILE: hdl/sibt_req_if.sv
// request channel: one lookup, mark or table load per transaction
`timescale 1ns / 1ps

interface sibt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [47:0] byte_offset;
    logic [11:0] entry_index;
    logic [63:0] entry_value;
    logic [31:0] fill_pattern;

    modport source (output valid, opcode, byte_offset, entry_index, entry_value, fill_pattern,
                    input ready);
    modport sink   (input valid, opcode, byte_offset, entry_index, entry_value, fill_pattern,
                    output ready);
endinterface

FILE: hdl/sibt_rsp_if.sv
// result channel: one translation result per transaction
`timescale 1ns / 1ps

interface sibt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] mapped_offset;
    logic [31:0] pattern;
    logic [1:0]  fill_action;
    logic [47:0] new_table_offset;
    logic        l1_changed;
    logic        l2_changed;
    logic [47:0] file_end;

    modport source (output valid, status, mapped_offset, pattern, fill_action,
                    new_table_offset, l1_changed, l2_changed, file_end,
                    input ready);
    modport sink   (input valid, status, mapped_offset, pattern, fill_action,
                    new_table_offset, l1_changed, l2_changed, file_end,
                    output ready);
endinterface

FILE: hdl/sibt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module sibt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sibt_cfg.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module sibt_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sibt_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready,
    output sibt_pkg::sibt_cfg_t            cfg
);

    logic [4:0]                    block_bits_reg;
    logic [2:0]                    l2_bits_reg;
    logic [2:0]                    l1_bits_reg;
    logic [sibt_pkg::OFS_W-1:0]    file_end_reg;
    logic                          wr_en;
    logic [1:0]                    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bits_reg <= 5'd12;
            l2_bits_reg    <= 3'd6;
            l1_bits_reg    <= 3'd6;
            file_end_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                sibt_pkg::REG_BLOCK_BITS: block_bits_reg <= pwdata[4:0];
                sibt_pkg::REG_L2_BITS:    l2_bits_reg    <= pwdata[2:0];
                sibt_pkg::REG_L1_BITS:    l1_bits_reg    <= pwdata[2:0];
                sibt_pkg::REG_FILE_END:   file_end_reg   <= pwdata[sibt_pkg::OFS_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            sibt_pkg::REG_BLOCK_BITS: prdata = {59'd0, block_bits_reg};
            sibt_pkg::REG_L2_BITS:    prdata = {61'd0, l2_bits_reg};
            sibt_pkg::REG_L1_BITS:    prdata = {61'd0, l1_bits_reg};
            sibt_pkg::REG_FILE_END:   prdata = {16'd0, file_end_reg};
            default:                  prdata = '0;
        endcase
    end

    // the allocator takes the new file end at the same edge as the register
    assign cfg.block_bits       = block_bits_reg;
    assign cfg.l2_bits          = l2_bits_reg;
    assign cfg.l1_bits          = l1_bits_reg;
    assign cfg.initial_file_end = pwdata[sibt_pkg::OFS_W-1:0];
    assign cfg.load_file_end    = wr_en && (reg_sel == sibt_pkg::REG_FILE_END);

endmodule

FILE: hdl/sparse_image_block_translator_core.sv
// top level: two-level sparse disk image block translator
`timescale 1ns / 1ps

// Translates disk byte offsets through an L1 table (64 words) and an L2 store
// (4096 words, one 64-word region per L1 slot), both held in synchronous RAMs
// with registered read data. One request is worked on at a time. Steps from
// acceptance to a valid result:
// - a read or write lookup whose L2 table exists: decode, L1 read, L2 read, result
// - set-uniform: decode, L1 read, L2 write, result
// - a read or write lookup that stops at the L1 word (missing on read, bad flags):
//   decode, L1 read, result
// - the table loads, an unknown opcode, a slot past the table and an unaligned
//   set-uniform: decode, result
// A write or set-uniform that finds no L2 table first zeroes the new region one
// word per cycle; the write lookup then rereads the L2 word.
// The next request is taken in the cycle after the result is parked in the output
// register, even while the sink is still stalling it. A result waits in its last
// state while the output register still holds an unaccepted result.
// Neither table is cleared by reset; load both before translating. The
// allocator pointer reloads whenever initial_file_end is written, and
// configuration may only change while no transaction is in flight.
module sparse_image_block_translator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    sibt_req_if.sink                       req,
    sibt_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sibt_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    sibt_pkg::sibt_cfg_t cfg;

    sibt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------- state
    sibt_pkg::sibt_state_t          state_reg, state_next;

    // captured request
    logic [2:0]                     op_reg, op_next;
    logic [sibt_pkg::OFS_W-1:0]     ofs_reg, ofs_next;
    logic [11:0]                    eidx_reg, eidx_next;
    logic [sibt_pkg::WORD_W-1:0]    eval_reg, eval_next;
    logic [sibt_pkg::PAT_W-1:0]     pat_reg, pat_next;

    // decoded offset fields
    logic [sibt_pkg::L1_AW-1:0]     slot_reg, slot_next;
    logic [sibt_pkg::L2_AW-1:0]     l2idx_reg, l2idx_next;
    logic [sibt_pkg::OFS_W-1:0]     bidx_reg, bidx_next;
    logic [sibt_pkg::OFS_W-1:0]     bmask_reg, bmask_next;

    logic [sibt_pkg::L2_AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [sibt_pkg::OFS_W-1:0]     alloc_reg, alloc_next;

    sibt_pkg::sibt_result_t         wrk_reg, wrk_next;
    sibt_pkg::sibt_result_t         out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    // ------------------------------------------------------------- memories
    logic                           l1_we;
    logic [sibt_pkg::L1_AW-1:0]     l1_waddr, l1_raddr;
    logic [sibt_pkg::WORD_W-1:0]    l1_wdata, l1_rdata;
    logic                           l2_we;
    logic [sibt_pkg::STORE_AW-1:0]  l2_waddr, l2_raddr;
    logic [sibt_pkg::WORD_W-1:0]    l2_wdata, l2_rdata;

    sibt_ram #(
        .WIDTH (sibt_pkg::WORD_W),
        .DEPTH (sibt_pkg::L1_DEPTH)
    ) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .raddr (l1_raddr),
        .rdata (l1_rdata)
    );

    sibt_ram #(
        .WIDTH (sibt_pkg::WORD_W),
        .DEPTH (sibt_pkg::STORE_DEPTH)
    ) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .raddr (l2_raddr),
        .rdata (l2_rdata)
    );

    // ------------------------------------------------ effective geometry
    logic [sibt_pkg::SH_W-1:0]      bb_eff, lb_eff, l1b_eff;
    logic [sibt_pkg::L2_AW-1:0]     lb_mask;
    logic [sibt_pkg::OFS_W-1:0]     dec_slot_full, dec_bmask, dec_bidx;
    logic [sibt_pkg::L2_AW-1:0]     dec_l2idx;
    logic                           dec_slot_bad;
    logic [sibt_pkg::STORE_AW-1:0]  l2_pos;
    logic [sibt_pkg::OFS_W-1:0]     word_offset;
    logic                           req_fire, rsp_fire;

    always_comb
    begin
        if (int'(cfg.block_bits) < sibt_pkg::MIN_BLOCK_BITS)
        begin
            bb_eff = sibt_pkg::SH_W'(sibt_pkg::MIN_BLOCK_BITS);
        end
        else if (int'(cfg.block_bits) > sibt_pkg::MAX_BLOCK_BITS)
        begin
            bb_eff = sibt_pkg::SH_W'(sibt_pkg::MAX_BLOCK_BITS);
        end
        else
        begin
            bb_eff = sibt_pkg::SH_W'(cfg.block_bits);
        end
    end

    assign lb_eff  = (int'(cfg.l2_bits) > sibt_pkg::MAX_L2_BITS) ?
                     sibt_pkg::SH_W'(sibt_pkg::MAX_L2_BITS) : sibt_pkg::SH_W'(cfg.l2_bits);
    assign l1b_eff = (int'(cfg.l1_bits) > sibt_pkg::MAX_L1_BITS) ?
                     sibt_pkg::SH_W'(sibt_pkg::MAX_L1_BITS) : sibt_pkg::SH_W'(cfg.l1_bits);
    assign lb_mask = sibt_pkg::L2_AW'((64'd1 << lb_eff) - 64'd1);

    // offset split: slot above block+l2 bits, l2 index, byte within block
    assign dec_slot_full = ofs_reg >> (bb_eff + lb_eff);
    assign dec_slot_bad  = (ofs_reg >> (bb_eff + lb_eff + l1b_eff)) != '0;
    assign dec_l2idx     = sibt_pkg::L2_AW'(ofs_reg >> bb_eff) & lb_mask;
    assign dec_bmask     = (48'd1 << bb_eff) - 48'd1;
    assign dec_bidx      = ofs_reg & dec_bmask;

    assign l2_pos        = {slot_reg, l2idx_reg};
    // block base from an L2 word plus the byte index, wrapped to 48 bits
    assign word_offset   = (l2_rdata[sibt_pkg::OFS_W-1:0] & ~bmask_reg) + bidx_reg;

    assign req_fire  = req.valid & req.ready;
    assign rsp_fire  = rsp.valid & rsp.ready;
    assign req.ready = (state_reg == sibt_pkg::S_IDLE);

    // ------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ofs_next       = ofs_reg;
        eidx_next      = eidx_reg;
        eval_next      = eval_reg;
        pat_next       = pat_reg;
        slot_next      = slot_reg;
        l2idx_next     = l2idx_reg;
        bidx_next      = bidx_reg;
        bmask_next     = bmask_reg;
        clr_cnt_next   = clr_cnt_reg;
        alloc_next     = alloc_reg;
        wrk_next       = wrk_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        l1_we    = 1'b0;
        l1_waddr = slot_reg;
        l1_wdata = {16'd0, alloc_reg};
        l1_raddr = slot_reg;
        l2_we    = 1'b0;
        l2_waddr = l2_pos;
        l2_wdata = '0;
        l2_raddr = l2_pos;

        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sibt_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next         = req.opcode;
                    ofs_next        = req.byte_offset;
                    eidx_next       = req.entry_index;
                    eval_next       = req.entry_value;
                    pat_next        = req.fill_pattern;
                    wrk_next        = '0;
                    wrk_next.status = sibt_pkg::STATUS_ERROR;
                    state_next      = sibt_pkg::S_DECODE;
                end
            end

            sibt_pkg::S_DECODE:
            begin
                slot_next  = dec_slot_full[sibt_pkg::L1_AW-1:0];
                l2idx_next = dec_l2idx;
                bidx_next  = dec_bidx;
                bmask_next = dec_bmask;
                state_next = sibt_pkg::S_RESULT;
                case (op_reg)
                    sibt_pkg::OP_READ, sibt_pkg::OP_WRITE, sibt_pkg::OP_UNIFORM:
                    begin
                        // unaligned set-uniform or slot past the table: error
                        if (!dec_slot_bad &&
                            !(op_reg == sibt_pkg::OP_UNIFORM && dec_bidx != '0))
                        begin
                            l1_raddr   = dec_slot_full[sibt_pkg::L1_AW-1:0];
                            state_next = sibt_pkg::S_L1_CHECK;
                        end
                    end
                    sibt_pkg::OP_LOAD_L1:
                    begin
                        l1_we           = (32'(eidx_reg) < sibt_pkg::L1_DEPTH);
                        l1_waddr        = sibt_pkg::L1_AW'(eidx_reg);
                        l1_wdata        = eval_reg;
                        wrk_next.status = sibt_pkg::STATUS_DONE;
                    end
                    sibt_pkg::OP_LOAD_L2:
                    begin
                        l2_we           = (32'(eidx_reg) < sibt_pkg::STORE_DEPTH);
                        l2_waddr        = sibt_pkg::STORE_AW'(eidx_reg);
                        l2_wdata        = eval_reg;
                        wrk_next.status = sibt_pkg::STATUS_DONE;
                    end
                    default:
                    begin
                        wrk_next.status = sibt_pkg::STATUS_ERROR;
                    end
                endcase
            end

            sibt_pkg::S_L1_CHECK:
            begin
                if (l1_rdata == '0)
                begin
                    if (op_reg == sibt_pkg::OP_READ)
                    begin
                        wrk_next.status = sibt_pkg::STATUS_UNALLOC;
                        state_next      = sibt_pkg::S_RESULT;
                    end
                    else
                    begin
                        // new L2 table at the file end, then zero its region
                        l1_we                     = 1'b1;
                        wrk_next.new_table_offset = alloc_reg;
                        wrk_next.l1_changed       = 1'b1;
                        wrk_next.l2_changed       = 1'b1;
                        alloc_next   = alloc_reg + (48'd1 << (lb_eff + sibt_pkg::SH_W'(3)));
                        clr_cnt_next = '0;
                        state_next   = sibt_pkg::S_CLEAR;
                    end
                end
                else if ((l1_rdata & sibt_pkg::LOW_FLAGS) != '0)
                begin
                    wrk_next.status = sibt_pkg::STATUS_ERROR;
                    state_next      = sibt_pkg::S_RESULT;
                end
                else if (op_reg == sibt_pkg::OP_UNIFORM)
                begin
                    state_next = sibt_pkg::S_UNI_WRITE;
                end
                else
                begin
                    state_next = sibt_pkg::S_L2_CHECK;
                end
            end

            sibt_pkg::S_CLEAR:
            begin
                l2_we        = 1'b1;
                l2_waddr     = {slot_reg, clr_cnt_reg};
                l2_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + sibt_pkg::L2_AW'(1);
                if (clr_cnt_reg == lb_mask)
                begin
                    state_next = (op_reg == sibt_pkg::OP_WRITE) ?
                                 sibt_pkg::S_L2_READ : sibt_pkg::S_UNI_WRITE;
                end
            end

            sibt_pkg::S_L2_READ:
            begin
                // read issued after the last clearing write has landed
                state_next = sibt_pkg::S_L2_CHECK;
            end

            sibt_pkg::S_L2_CHECK:
            begin
                state_next = sibt_pkg::S_RESULT;
                if (op_reg == sibt_pkg::OP_READ)
                begin
                    if (l2_rdata == '0)
                    begin
                        wrk_next.status = sibt_pkg::STATUS_UNALLOC;
                    end
                    else if ((l2_rdata & sibt_pkg::UNIFORM_MARK) != '0)
                    begin
                        wrk_next.status  = sibt_pkg::STATUS_UNIFORM;
                        wrk_next.pattern = l2_rdata[63:32];
                    end
                    else if ((l2_rdata & sibt_pkg::LOW_FLAGS) != '0)
                    begin
                        wrk_next.status = sibt_pkg::STATUS_ERROR;
                    end
                    else
                    begin
                        wrk_next.status        = sibt_pkg::STATUS_MAPPED;
                        wrk_next.mapped_offset = word_offset;
                    end
                end
                else
                begin
                    if (l2_rdata == '0 || (l2_rdata & sibt_pkg::UNIFORM_MARK) != '0)
                    begin
                        // missing or uniform block: allocate a data block
                        if (l2_rdata == '0)
                        begin
                            wrk_next.fill_action = sibt_pkg::FILL_COPY;
                        end
                        else
                        begin
                            wrk_next.fill_action = sibt_pkg::FILL_PATTERN;
                            wrk_next.pattern     = l2_rdata[63:32];
                        end
                        l2_we                  = 1'b1;
                        l2_wdata               = {16'd0, alloc_reg};
                        wrk_next.mapped_offset = alloc_reg + bidx_reg;
                        wrk_next.l2_changed    = 1'b1;
                        wrk_next.status        = sibt_pkg::STATUS_MAPPED;
                        alloc_next             = alloc_reg + (48'd1 << bb_eff);
                    end
                    else if ((l2_rdata & sibt_pkg::LOW_FLAGS) != '0)
                    begin
                        wrk_next.status = sibt_pkg::STATUS_ERROR;
                    end
                    else
                    begin
                        wrk_next.status        = sibt_pkg::STATUS_MAPPED;
                        wrk_next.mapped_offset = word_offset;
                    end
                end
            end

            sibt_pkg::S_UNI_WRITE:
            begin
                l2_we               = 1'b1;
                l2_wdata            = {pat_reg, 32'd0} | sibt_pkg::UNIFORM_MARK;
                wrk_next.l2_changed = 1'b1;
                wrk_next.status     = sibt_pkg::STATUS_DONE;
                state_next          = sibt_pkg::S_RESULT;
            end

            sibt_pkg::S_RESULT:
            begin
                // park the result once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next          = wrk_reg;
                    out_next.file_end = alloc_reg;
                    out_valid_next    = 1'b1;
                    state_next        = sibt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sibt_pkg::S_IDLE;
            end
        endcase

        // a file end write reloads the allocator
        if (cfg.load_file_end)
        begin
            alloc_next = cfg.initial_file_end;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sibt_pkg::S_IDLE;
            alloc_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ofs_reg     <= ofs_next;
        eidx_reg    <= eidx_next;
        eval_reg    <= eval_next;
        pat_reg     <= pat_next;
        slot_reg    <= slot_next;
        l2idx_reg   <= l2idx_next;
        bidx_reg    <= bidx_next;
        bmask_reg   <= bmask_next;
        clr_cnt_reg <= clr_cnt_next;
        wrk_reg     <= wrk_next;
        out_reg     <= out_next;
    end

    // ------------------------------------------------------------- outputs
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_reg.status;
    assign rsp.mapped_offset    = out_reg.mapped_offset;
    assign rsp.pattern          = out_reg.pattern;
    assign rsp.fill_action      = out_reg.fill_action;
    assign rsp.new_table_offset = out_reg.new_table_offset;
    assign rsp.l1_changed       = out_reg.l1_changed;
    assign rsp.l2_changed       = out_reg.l2_changed;
    assign rsp.file_end         = out_reg.file_end;

endmodule

FILE: hdl/sibt_checker.sv
// port-level checker for the translator, bound to the top level
`timescale 1ns / 1ps
`include "sparse_image_block_translator_core_assert.svh"

module sibt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [47:0] mapped_offset,
    input logic [1:0]  fill_action,
    input logic        l1_changed,
    input logic        l2_changed,
    input logic [47:0] file_end
);

    // a stalled result stays up with its status and file end unchanged
    `SIBT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(file_end))

    // one transaction in flight: no acceptance right after another
    `SIBT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // a fill action only comes with a freshly mapped and linked block
    `SIBT_ASSERT_SAME(a_fill_mapped, clk, rst_n, rsp_valid && fill_action != sibt_pkg::FILL_NONE, status == sibt_pkg::STATUS_MAPPED && l2_changed)

    // an unallocated answer changes no table and gives no offset
    `SIBT_ASSERT_SAME(a_unalloc_clean, clk, rst_n, rsp_valid && status == sibt_pkg::STATUS_UNALLOC, !l1_changed && !l2_changed && mapped_offset == 48'd0)

endmodule

bind sparse_image_block_translator_core sibt_checker u_sibt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .mapped_offset (rsp.mapped_offset),
    .fill_action   (rsp.fill_action),
    .l1_changed    (rsp.l1_changed),
    .l2_changed    (rsp.l2_changed),
    .file_end      (rsp.file_end)
);
